// ----- design/assert_macros.svh -----
// Assertion helpers used by triangle_tangent_bitangent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TTB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ttb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttb_pkg
// Widths and types shared by the tangent/bitangent pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttb_pkg;

    localparam int POS_W   = 48;
    localparam int UV_W    = 32;
    localparam int CMP_W   = 16;
    localparam int EDGE_W  = CMP_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int MAG_W   = SUM_W;
    localparam int FRAC_SH = 13;          // 4096 scale plus one bit for rounding
    localparam int Q_W     = 18;          // quotient bits of 2*n*4096/d
    localparam int REM_W   = MAG_W + Q_W;
    localparam int LANES   = 6;

    typedef struct packed {
        logic                        valid;
        logic                        deg;
        logic [MAG_W-1:0]            den;
        logic [LANES-1:0][MAG_W-1:0] num;
        logic [LANES-1:0]            neg;
    } t_front;

endpackage

// ----- design/ttb_front.sv -----
// ----------------------------------------------------------------------------
// ttb_front
// Edge and uv deltas, products, numerators and magnitudes in four stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttb_front
    import ttb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [POS_W-1:0] i_pos0,
    input  logic [POS_W-1:0] i_pos1,
    input  logic [POS_W-1:0] i_pos2,
    input  logic [UV_W-1:0]  i_uv0,
    input  logic [UV_W-1:0]  i_uv1,
    input  logic [UV_W-1:0]  i_uv2,
    output t_front           o_front
);

    logic r_v_a, r_v_b, r_v_c, r_v_d;

    logic signed [EDGE_W-1:0] n_e1 [3], n_e2 [3], r_e1 [3], r_e2 [3];
    logic signed [EDGE_W-1:0] n_du1, n_dv1, n_du2, n_dv2;
    logic signed [EDGE_W-1:0] r_du1, r_dv1, r_du2, r_dv2;

    logic signed [PROD_W-1:0] r_pda, r_pdb;
    logic signed [PROD_W-1:0] r_pt1 [3], r_pt2 [3], r_pb1 [3], r_pb2 [3];

    logic signed [SUM_W-1:0] r_det, r_tn [3], r_bn [3];

    t_front n_front, r_front;

    function automatic logic signed [EDGE_W-1:0] f_sub(input logic [CMP_W-1:0] a,
                                                        input logic [CMP_W-1:0] b);
        return $signed({a[CMP_W-1], a}) - $signed({b[CMP_W-1], b});
    endfunction

    function automatic logic [MAG_W-1:0] f_abs(input logic signed [SUM_W-1:0] x);
        return x[SUM_W-1] ? (~x + 1'b1) : x;
    endfunction

    // stage A: differences
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_e1[k] = f_sub(i_pos1[CMP_W*k +: CMP_W], i_pos0[CMP_W*k +: CMP_W]);
            n_e2[k] = f_sub(i_pos2[CMP_W*k +: CMP_W], i_pos0[CMP_W*k +: CMP_W]);
        end
        n_du1 = f_sub(i_uv1[CMP_W-1:0],     i_uv0[CMP_W-1:0]);
        n_dv1 = f_sub(i_uv1[2*CMP_W-1:CMP_W], i_uv0[2*CMP_W-1:CMP_W]);
        n_du2 = f_sub(i_uv2[CMP_W-1:0],     i_uv0[CMP_W-1:0]);
        n_dv2 = f_sub(i_uv2[2*CMP_W-1:CMP_W], i_uv0[2*CMP_W-1:CMP_W]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1  <= n_e1;
            r_e2  <= n_e2;
            r_du1 <= n_du1;
            r_dv1 <= n_dv1;
            r_du2 <= n_du2;
            r_dv2 <= n_dv2;
        end
    end

    // stage B: products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pda <= r_du1 * r_dv2;
            r_pdb <= r_du2 * r_dv1;
            for (int k = 0; k < 3; k++) begin
                r_pt1[k] <= r_dv2 * r_e1[k];
                r_pt2[k] <= r_dv1 * r_e2[k];
                r_pb1[k] <= r_du1 * r_e2[k];
                r_pb2[k] <= r_du2 * r_e1[k];
            end
        end
    end

    // stage C: determinant and numerators
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= SUM_W'(r_pda) - SUM_W'(r_pdb);
            for (int k = 0; k < 3; k++) begin
                r_tn[k] <= SUM_W'(r_pt1[k]) - SUM_W'(r_pt2[k]);
                r_bn[k] <= SUM_W'(r_pb1[k]) - SUM_W'(r_pb2[k]);
            end
        end
    end

    // stage D: magnitudes and signs
    always_comb begin
        n_front       = '0;
        n_front.valid = r_v_c;
        n_front.deg   = (r_det == '0);
        n_front.den   = f_abs(r_det);
        for (int k = 0; k < 3; k++) begin
            n_front.num[k]     = f_abs(r_tn[k]);
            n_front.num[k + 3] = f_abs(r_bn[k]);
            n_front.neg[k]     = r_tn[k][SUM_W-1] ^ r_det[SUM_W-1];
            n_front.neg[k + 3] = r_bn[k][SUM_W-1] ^ r_det[SUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
        end else if (i_en) begin
            r_v_a <= i_valid;
            r_v_b <= r_v_a;
            r_v_c <= r_v_b;
            r_v_d <= n_front.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    // valid comes from the reset register, the rest from the data register
    always_comb begin
        o_front       = r_front;
        o_front.valid = r_v_d;
    end

endmodule

// ----- design/ttb_div_lane.sv -----
// ----------------------------------------------------------------------------
// ttb_div_lane
// Pipelined restoring divider: floor(2*n*4096/d), one quotient bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttb_div_lane
    import ttb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [MAG_W-1:0] i_num,
    input  logic [MAG_W-1:0] i_den,
    input  logic             i_neg,
    output logic [Q_W-1:0]   o_quo,
    output logic             o_ovf,
    output logic             o_neg
);

    logic [REM_W-1:0] r_rem [Q_W+1];
    logic [REM_W-1:0] r_den [Q_W+1];
    logic [Q_W-1:0]   r_quo [Q_W+1];
    logic             r_ovf [Q_W+1];
    logic             r_neg [Q_W+1];

    logic [REM_W-1:0] n_rem0, n_den0;

    // entry stage: scale numerator, flag quotients too large for Q_W bits
    assign n_rem0 = {{(REM_W-MAG_W-FRAC_SH){1'b0}}, i_num, {FRAC_SH{1'b0}}};
    assign n_den0 = {{Q_W{1'b0}}, i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem0;
            r_den[0] <= n_den0;
            r_quo[0] <= '0;
            r_ovf[0] <= (n_rem0 >= (n_den0 << Q_W));
            r_neg[0] <= i_neg;
        end
    end

    for (genvar s = 1; s <= Q_W; s++) begin : g_step
        logic [REM_W-1:0] n_dsh;
        logic             n_ge;

        assign n_dsh = r_den[s-1] << (Q_W - s);
        assign n_ge  = (r_rem[s-1] >= n_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_ge ? (r_rem[s-1] - n_dsh) : r_rem[s-1];
                r_den[s] <= r_den[s-1];
                r_quo[s] <= {r_quo[s-1][Q_W-2:0], n_ge};
                r_ovf[s] <= r_ovf[s-1];
                r_neg[s] <= r_neg[s-1];
            end
        end
    end

    assign o_quo = r_quo[Q_W];
    assign o_ovf = r_ovf[Q_W];
    assign o_neg = r_neg[Q_W];

endmodule

// ----- design/triangle_tangent_bitangent.sv -----
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent
// Per-triangle tangent and bitangent in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  input    | in        | i_valid / o_stall  | i_pos0..2 (Q8.8 zyx), i_uv0..2 (Q4.12 vu)
//  output   | out       | o_valid / i_stall  | o_tangent, o_bitangent, o_degenerate, o_clipped
//
//  One beat accepted per cycle while o_stall is low; the pipe holds 4 front stages (deltas,
//  products, numerators, magnitudes), 19 divider stages, 1 output register.
//  The divider depth (one quotient bit a stage) sets the latency.
//  A stalled output beat freezes the whole pipe; o_stall rises only then.
//  Reset is synchronous, active low, and clears the valid bits only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module triangle_tangent_bitangent
    import ttb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [POS_W-1:0] i_pos0,
    input  logic [POS_W-1:0] i_pos1,
    input  logic [POS_W-1:0] i_pos2,
    input  logic [UV_W-1:0]  i_uv0,
    input  logic [UV_W-1:0]  i_uv1,
    input  logic [UV_W-1:0]  i_uv2,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [POS_W-1:0] o_tangent,
    output logic [POS_W-1:0] o_bitangent,
    output logic             o_degenerate,
    output logic             o_clipped
);

    localparam logic [CMP_W-1:0] SAT_POS = {1'b0, {(CMP_W-1){1'b1}}};
    localparam logic [CMP_W-1:0] SAT_NEG = {1'b1, {(CMP_W-1){1'b0}}};

    // global advance: pipe moves unless a finished beat is held at the output
    logic   en;
    t_front front;

    logic [LANES-1:0][Q_W-1:0] quo;
    logic [LANES-1:0]          ovf, neg;

    // valid and degenerate flags ride alongside the divider stages
    logic r_vl [Q_W+1];
    logic r_dg [Q_W+1];

    logic [LANES-1:0][CMP_W-1:0] n_cmp;
    logic [LANES-1:0]            n_sat;

    logic             r_o_valid;
    logic [POS_W-1:0] r_tan, r_bit;
    logic             r_deg, r_clip;
    logic             any_rail;

    assign en      = !r_o_valid || !i_stall;
    assign o_stall = !en;

    ttb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_pos0  (i_pos0),
        .i_pos1  (i_pos1),
        .i_pos2  (i_pos2),
        .i_uv0   (i_uv0),
        .i_uv1   (i_uv1),
        .i_uv2   (i_uv2),
        .o_front (front)
    );

    // lanes 0..2: tangent x,y,z; lanes 3..5: bitangent x,y,z
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        ttb_div_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (front.num[l]),
            .i_den (front.den),
            .i_neg (front.neg[l]),
            .o_quo (quo[l]),
            .o_ovf (ovf[l]),
            .o_neg (neg[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= Q_W; s++) r_vl[s] <= 1'b0;
        end else if (en) begin
            r_vl[0] <= front.valid;
            for (int s = 1; s <= Q_W; s++) r_vl[s] <= r_vl[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dg[0] <= front.deg;
            for (int s = 1; s <= Q_W; s++) r_dg[s] <= r_dg[s-1];
        end
    end

    // round half away from zero: q = (floor(2n*4096/d) + 1) / 2, then apply sign and clamp
    always_comb begin
        logic [Q_W:0] qr;
        for (int l = 0; l < LANES; l++) begin
            qr       = ({1'b0, quo[l]} + 1'b1) >> 1;
            n_sat[l] = ovf[l]
                    || (!neg[l] && (qr > (Q_W+1)'(SAT_POS)))
                    || ( neg[l] && (qr > (Q_W+1)'(SAT_NEG)));
            if (n_sat[l]) begin
                n_cmp[l] = neg[l] ? SAT_NEG : SAT_POS;
            end else begin
                n_cmp[l] = neg[l] ? (~qr[CMP_W-1:0] + 1'b1) : qr[CMP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_vl[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_deg  <= r_dg[Q_W];
            r_clip <= !r_dg[Q_W] && (|n_sat);
            r_tan  <= r_dg[Q_W] ? '0 : {n_cmp[2], n_cmp[1], n_cmp[0]};
            r_bit  <= r_dg[Q_W] ? '0 : {n_cmp[5], n_cmp[4], n_cmp[3]};
        end
    end

    assign o_valid      = r_o_valid;
    assign o_tangent    = r_tan;
    assign o_bitangent  = r_bit;
    assign o_degenerate = r_deg;
    assign o_clipped    = r_clip;

    assign any_rail = (r_tan[15:0]  == SAT_POS) || (r_tan[15:0]  == SAT_NEG)
                   || (r_tan[31:16] == SAT_POS) || (r_tan[31:16] == SAT_NEG)
                   || (r_tan[47:32] == SAT_POS) || (r_tan[47:32] == SAT_NEG)
                   || (r_bit[15:0]  == SAT_POS) || (r_bit[15:0]  == SAT_NEG)
                   || (r_bit[31:16] == SAT_POS) || (r_bit[31:16] == SAT_NEG)
                   || (r_bit[47:32] == SAT_POS) || (r_bit[47:32] == SAT_NEG);

    `TTB_ASSERT_NOW(a_deg_zero, o_valid && o_degenerate, (o_tangent == '0) && (o_bitangent == '0) && !o_clipped, "degenerate beat carries non-zero vectors")
    `TTB_ASSERT_NOW(a_clip_rail, o_valid && o_clipped, any_rail, "clipped beat has no component at a rail")
    `TTB_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall, "input stalled without a held output beat")
    `TTB_ASSERT_NEXT(a_hold_beat, o_valid && i_stall, o_valid, "held output beat lost")

endmodule

// ----- test/ttb_checker.sv -----
// ----------------------------------------------------------------------------
// ttb_checker
// Watches both channels, predicts each triangle's tangent frame, compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttb_checker
    import ttb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_in_stall,
    input  logic [POS_W-1:0] i_pos0,
    input  logic [POS_W-1:0] i_pos1,
    input  logic [POS_W-1:0] i_pos2,
    input  logic [UV_W-1:0]  i_uv0,
    input  logic [UV_W-1:0]  i_uv1,
    input  logic [UV_W-1:0]  i_uv2,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [POS_W-1:0] i_tangent,
    input  logic [POS_W-1:0] i_bitangent,
    input  logic             i_degenerate,
    input  logic             i_clipped,
    output int               o_errors,
    output int               o_pending,
    output int               o_frames,
    output int               o_degen_seen,
    output int               o_clip_seen
);

    typedef struct {
        logic [POS_W-1:0] tan;
        logic [POS_W-1:0] bit_v;
        logic             deg;
        logic             clip;
    } t_frame;

    t_frame frame_q[$];

    function automatic longint lane(logic [63:0] w, int k);
        return longint'($signed(w[16*k +: 16]));
    endfunction

    // num * 4096 / den, round half away from zero, saturate to Q8.8
    function automatic logic [15:0] quot_q88(longint num, longint den, ref logic sat);
        logic    neg;
        longint  n, d, q;
        neg = (num < 0) != (den < 0);
        n = (num < 0 ? -num : num) <<< 12;
        d = den < 0 ? -den : den;
        q = (2 * n + d) / (2 * d);
        if (num == 0) q = 0;
        if (!neg && q > 32767) begin
            sat = 1'b1;
            return 16'h7fff;
        end
        if (neg && q > 32768) begin
            sat = 1'b1;
            return 16'h8000;
        end
        return neg ? 16'(-q) : 16'(q);
    endfunction

    function automatic t_frame tangent_frame(logic [POS_W-1:0] p0, logic [POS_W-1:0] p1,
                                             logic [POS_W-1:0] p2, logic [UV_W-1:0] t0,
                                             logic [UV_W-1:0] t1, logic [UV_W-1:0] t2);
        t_frame f;
        longint e1, e2, du1, dv1, du2, dv2, det;
        logic   sat;
        du1 = lane(t1, 0) - lane(t0, 0);
        dv1 = lane(t1, 1) - lane(t0, 1);
        du2 = lane(t2, 0) - lane(t0, 0);
        dv2 = lane(t2, 1) - lane(t0, 1);
        det = du1 * dv2 - du2 * dv1;
        f.tan = '0;
        f.bit_v = '0;
        f.deg = (det == 0);
        sat = 1'b0;
        if (det != 0) begin
            for (int k = 0; k < 3; k++) begin
                e1 = lane(p1, k) - lane(p0, k);
                e2 = lane(p2, k) - lane(p0, k);
                f.tan[16*k +: 16]   = quot_q88(dv2 * e1 - dv1 * e2, det, sat);
                f.bit_v[16*k +: 16] = quot_q88(du1 * e2 - du2 * e1, det, sat);
            end
        end
        f.clip = sat;
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall)
                frame_q.push_back(tangent_frame(i_pos0, i_pos1, i_pos2, i_uv0, i_uv1, i_uv2));
            if (i_out_valid && !i_out_stall) begin
                if (frame_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_errors++;
                end else begin
                    want = frame_q.pop_front();
                    o_frames++;
                    if (i_degenerate) o_degen_seen++;
                    if (i_clipped) o_clip_seen++;
                    if (i_tangent !== want.tan) begin
                        $error("tangent: expected %h got %h", want.tan, i_tangent);
                        o_errors++;
                    end
                    if (i_bitangent !== want.bit_v) begin
                        $error("bitangent: expected %h got %h", want.bit_v, i_bitangent);
                        o_errors++;
                    end
                    if (i_degenerate !== want.deg) begin
                        $error("degenerate: expected %b got %b", want.deg, i_degenerate);
                        o_errors++;
                    end
                    if (i_clipped !== want.clip) begin
                        $error("clipped: expected %b got %b", want.clip, i_clipped);
                        o_errors++;
                    end
                end
            end
        end
        o_pending <= frame_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_frames = 0;
        o_degen_seen = 0;
        o_clip_seen = 0;
    end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives triangles into triangle_tangent_bitangent under varied flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import ttb_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [POS_W-1:0] i_pos0 = '0, i_pos1 = '0, i_pos2 = '0;
    logic [UV_W-1:0]  i_uv0 = '0, i_uv1 = '0, i_uv2 = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [POS_W-1:0] o_tangent, o_bitangent;
    logic             o_degenerate, o_clipped;

    int errors, pending, frames, degen_seen, clip_seen;
    int send_idle_pct, recv_idle_pct;   // percent of cycles each side idles
    int beats_sent;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    triangle_tangent_bitangent dut (.*);

    ttb_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall),
        .i_pos0, .i_pos1, .i_pos2, .i_uv0, .i_uv1, .i_uv2,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_tangent(o_tangent), .i_bitangent(o_bitangent),
        .i_degenerate(o_degenerate), .i_clipped(o_clipped),
        .o_errors(errors), .o_pending(pending), .o_frames(frames),
        .o_degen_seen(degen_seen), .o_clip_seen(clip_seen)
    );

    // receiver back-pressure, redrawn every rising edge
    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < recv_idle_pct);

    // random vertex lane: half small, a quarter any value, a quarter the extremes
    function automatic logic [15:0] rand_lane();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2, 3: return 16'($urandom);
            default: return 16'($signed($urandom_range(1023)) - 512);
        endcase
    endfunction

    function automatic logic [47:0] rand_pos();
        return {rand_lane(), rand_lane(), rand_lane()};
    endfunction

    // one triangle beat; holds valid across back-to-back beats
    task automatic send_tri(logic [47:0] p0, logic [47:0] p1, logic [47:0] p2,
                            logic [31:0] t0, logic [31:0] t1, logic [31:0] t2);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos0 <= p0; i_pos1 <= p1; i_pos2 <= p2;
        i_uv0 <= t0; i_uv1 <= t1; i_uv2 <= t2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic random_tri();
        logic [31:0] t0, t1, t2;
        t0 = {rand_lane(), rand_lane()};
        t1 = {rand_lane(), rand_lane()};
        t2 = {rand_lane(), rand_lane()};
        // now and then a collinear or repeated uv so the determinant vanishes
        if ($urandom_range(15) == 0) t2 = t1;
        if ($urandom_range(31) == 0) t1 = t0;
        send_tri(rand_pos(), rand_pos(), rand_pos(), t0, t1, t2);
    endtask

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        beats_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unit uv frame, extremes, zero determinant, saturation
        send_tri('0, 48'h0000_0000_0100, 48'h0000_0100_0000,
                 32'h0000_0000, 32'h0000_1000, 32'h1000_0000);
        send_tri('0, 48'h7fff_7fff_7fff, 48'h8000_8000_8000,
                 32'h0000_0000, 32'h0000_0001, 32'h0001_0000);
        send_tri('0, 48'h8000_8000_8000, 48'h7fff_7fff_7fff,
                 32'h0000_0000, 32'h0000_0001, 32'h0001_0000);
        send_tri(48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'h7fff_8000_7fff,
                 32'h8000_8000, 32'h7fff_7fff, 32'h8000_7fff);
        send_tri(48'h8000_8000_8000, 48'h7fff_7fff_7fff, '0,
                 32'h7fff_8000, 32'h8000_7fff, 32'h7fff_7fff);
        send_tri(48'h0100_0200_0300, 48'h0400_0500_0600, 48'h0700_0800_0900,
                 32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
        send_tri(48'h0100_0200_0300, 48'h0400_0500_0600, 48'h0700_0800_0900,
                 32'h0000_0000, 32'h1000_1000, 32'h2000_2000);
        send_tri('1, '1, '1, '1, '1, '1);
        send_tri('0, '0, '0, 32'h0000_0000, 32'h0000_1000, 32'h1000_0000);
        // rounding ties and sign mixes
        send_tri('0, 48'h0001_0001_0001, 48'hffff_ffff_ffff,
                 32'h0000_0000, 32'h0000_3000, 32'h3000_0000);
        send_tri('0, 48'h0003_fffd_0001, 48'h0002_0002_fffe,
                 32'h0000_0000, 32'hf000_2000, 32'h2000_f000);
        send_tri(48'h5555_aaaa_5555, 48'haaaa_5555_aaaa, 48'h0f0f_f0f0_0f0f,
                 32'h5555_aaaa, 32'haaaa_5555, 32'hf0f0_0f0f);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 78 : 0;
            recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 21 : 0;
            for (int n = 0; n < 500; n++) random_tri();
        end
        i_valid <= 1'b0;

        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        $display("%0d triangles sent, %0d results checked (%0d degenerate, %0d clipped)",
                 beats_sent, frames, degen_seen, clip_seen);
        $display("flow control: sender/receiver idle 21/78, 78/21, then none");
        if (errors == 0 && pending == 0)
            $display("triangle_tangent_bitangent regression: pass");
        else
            $display("triangle_tangent_bitangent regression: fail");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("triangle_tangent_bitangent regression: fail");
        $finish;
    end

endmodule
